### design/womr_pkg.sv
// Shared constants and types of the window outlier median replace unit.
`default_nettype none
package womr_pkg;
    localparam int HALF_WINDOW = 10;
    localparam int DEPTH       = 2 * HALF_WINDOW + 1;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SAMPLE_W    = 16;
    localparam int VALUE_W     = SAMPLE_W + 1;
    localparam int SIGMA_W     = 4;
    localparam logic [SIGMA_W-1:0] SIGMA_RESET = SIGMA_W'(2);
    localparam int SUM_W       = SAMPLE_W + CNT_W;
    localparam int SQ_W        = 2 * SAMPLE_W - 2 + CNT_W;
    localparam int DIFF_W      = SUM_W + 2;
    localparam int VAR_W       = SQ_W + CNT_W;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       emit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;
endpackage
`default_nettype wire

### design/womr_front.sv
// Request intake: classifies each sample by whether it releases a delayed result.
`default_nettype none
module womr_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [womr_pkg::SAMPLE_W-1:0]  in_sample,
    input  wire logic                           in_last,
    output logic                                in_ready,
    input  womr_pkg::q_stat_t                   q_stat,
    output logic                                push,
    output womr_pkg::cmd_t                      cmd
);
    import womr_pkg::*;

    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;
    logic [CNT_W:0]   pend_inc;

    assign in_ready   = !q_stat.full;
    assign push       = in_valid && in_ready;
    assign pend_inc   = {1'b0, pend_reg} + (CNT_W+1)'(1);
    assign cmd.sample = $signed(in_sample);
    assign cmd.last   = in_last;
    assign cmd.emit   = !in_last && (pend_inc > (CNT_W+1)'(HALF_WINDOW));

    always_comb
    begin
        priority if (in_last)
        begin
            pend_next = '0;
        end
        else if (cmd.emit)
        begin
            pend_next = pend_reg;
        end
        else
        begin
            pend_next = pend_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (push)
        begin
            pend_reg <= pend_next;
        end
    end
endmodule
`default_nettype wire

### design/womr_queue.sv
// Two-entry request queue between intake and the window engine.
`default_nettype none
module womr_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  womr_pkg::cmd_t       cmd_in,
    input  wire logic            pop,
    output womr_pkg::cmd_t       cmd_out,
    output womr_pkg::q_stat_t    stat
);
    import womr_pkg::*;

    cmd_t       mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign cmd_out    = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### design/womr_back.sv
// Window engine: shifts the window, forms sums and median, tests and emits results.
`default_nettype none
module womr_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [womr_pkg::SIGMA_W-1:0]  sigma,
    input  womr_pkg::q_stat_t                  q_stat,
    input  womr_pkg::cmd_t                     q_cmd,
    output logic                               pop,
    output logic                               out_valid,
    output logic [womr_pkg::VALUE_W-1:0]       out_value,
    output logic                               out_last,
    input  wire logic                          out_ready
);
    import womr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_M1   = 3'd2;
    localparam logic [2:0] S_M2   = 3'd3;
    localparam logic [2:0] S_M3   = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0]                  state_reg;
    logic signed [SAMPLE_W-1:0]  store_reg [0:DEPTH-1];
    logic [CNT_W-1:0]            fill_reg;
    logic [CNT_W-1:0]            fill_next;
    logic [CNT_W-1:0]            epos_reg;
    logic [IDX_W-1:0]            d_reg;
    logic [IDX_W-1:0]            hi_reg;
    logic [IDX_W-1:0]            j_reg;
    logic [CNT_W-1:0]            n_reg;
    logic                        job_last_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic signed [SAMPLE_W-1:0]  v1_reg;
    logic signed [SAMPLE_W-1:0]  v2_reg;
    logic signed [SAMPLE_W-1:0]  x_reg;
    logic signed [DIFF_W-1:0]    diff_reg;
    logic [2*SUM_W-1:0]          ss_reg;
    logic [VAR_W-1:0]            nq_reg;
    logic [2*SIGMA_W-1:0]        tt_reg;
    logic [VAR_W-1:0]            var_reg;
    logic [2*DIFF_W-1:0]         dsq_reg;
    logic [2*SIGMA_W+CNT_W-1:0]  ttn_reg;
    logic [2*DIFF_W+CNT_W-1:0]   lhs_reg;
    logic [2*SIGMA_W+CNT_W+VAR_W-1:0] rhs_reg;
    logic                        out_valid_reg;
    logic [VALUE_W-1:0]          out_value_reg;
    logic                        out_last_reg;

    logic [IDX_W-1:0]            d_start;
    logic [CNT_W-1:0]            fill_sel;
    logic [IDX_W:0]              reach;
    logic [IDX_W:0]              lim;
    logic [IDX_W-1:0]            hi_calc;
    logic signed [SAMPLE_W-1:0]  cand;
    logic [DEPTH-1:0]            lt_vec;
    logic [DEPTH-1:0]            le_vec;
    logic [CNT_W-1:0]            lt_cnt;
    logic [CNT_W-1:0]            le_cnt;
    logic [IDX_W-1:0]            m1;
    logic [IDX_W-1:0]            m2;
    logic signed [2*SAMPLE_W-1:0] cand_sq;
    logic signed [DIFF_W-1:0]    nx_w;
    logic signed [2*SUM_W-1:0]   ss_w;
    logic [DIFF_W-1:0]           dabs;
    logic signed [VALUE_W-1:0]   med;
    logic                        load_out;
    logic                        job_done;

    assign fill_next = (fill_reg == CNT_W'(DEPTH)) ? fill_reg : fill_reg + CNT_W'(1);
    assign d_start   = (state_reg == S_IDLE)
                     ? (q_cmd.last ? epos_reg[IDX_W-1:0] : IDX_W'(HALF_WINDOW))
                     : d_reg - IDX_W'(1);
    assign fill_sel  = (state_reg == S_IDLE) ? fill_next : fill_reg;
    assign reach     = {1'b0, d_start} + (IDX_W+1)'(HALF_WINDOW);
    assign lim       = (IDX_W+1)'(fill_sel) - (IDX_W+1)'(1);
    assign hi_calc   = (reach > lim) ? lim[IDX_W-1:0] : reach[IDX_W-1:0];

    assign cand    = store_reg[j_reg];
    assign cand_sq = cand * cand;
    assign m1      = hi_reg >> 1;
    assign m2      = IDX_W'(({1'b0, hi_reg} + (IDX_W+1)'(1)) >> 1);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            lt_vec[i] = (IDX_W'(i) <= hi_reg) && (store_reg[i] < cand);
            le_vec[i] = (IDX_W'(i) <= hi_reg) && (store_reg[i] <= cand);
        end
    end

    assign lt_cnt = CNT_W'($countones(lt_vec));
    assign le_cnt = CNT_W'($countones(le_vec));

    assign nx_w = $signed({1'b0, n_reg}) * x_reg;
    assign ss_w = sum_reg * sum_reg;
    assign dabs = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign med  = VALUE_W'(v1_reg) + VALUE_W'(v2_reg);

    assign pop      = (state_reg == S_IDLE) && !q_stat.empty;
    assign load_out = (state_reg == S_RES) && (!out_valid_reg || out_ready);
    assign job_done = !job_last_reg || (d_reg == '0);

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            store_reg[0] <= q_cmd.sample;
            for (int i = 1; i < DEPTH; i++)
            begin
                store_reg[i] <= store_reg[i-1];
            end
        end
        if (pop || (load_out && !job_done))
        begin
            d_reg   <= d_start;
            hi_reg  <= hi_calc;
            n_reg   <= CNT_W'(hi_calc) + CNT_W'(1);
            j_reg   <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        if (pop)
        begin
            job_last_reg <= q_cmd.last;
        end
        if (state_reg == S_ACC)
        begin
            sum_reg <= sum_reg + SUM_W'(cand);
            sq_reg  <= sq_reg + SQ_W'(unsigned'(cand_sq));
            j_reg   <= j_reg + IDX_W'(1);
            if (lt_cnt <= CNT_W'(m1) && CNT_W'(m1) < le_cnt)
            begin
                v1_reg <= cand;
            end
            if (lt_cnt <= CNT_W'(m2) && CNT_W'(m2) < le_cnt)
            begin
                v2_reg <= cand;
            end
            if (j_reg == d_reg)
            begin
                x_reg <= cand;
            end
        end
        if (state_reg == S_M1)
        begin
            diff_reg <= nx_w - DIFF_W'(sum_reg);
            ss_reg   <= unsigned'(ss_w);
            nq_reg   <= VAR_W'(n_reg) * VAR_W'(sq_reg);
            tt_reg   <= (2*SIGMA_W)'(sigma) * (2*SIGMA_W)'(sigma);
        end
        if (state_reg == S_M2)
        begin
            var_reg <= nq_reg - ss_reg[VAR_W-1:0];
            dsq_reg <= (2*DIFF_W)'(dabs) * (2*DIFF_W)'(dabs);
            ttn_reg <= (2*SIGMA_W+CNT_W)'(tt_reg) * (2*SIGMA_W+CNT_W)'(n_reg);
        end
        if (state_reg == S_M3)
        begin
            lhs_reg <= (2*DIFF_W+CNT_W)'(dsq_reg) * (2*DIFF_W+CNT_W)'(n_reg - CNT_W'(1));
            rhs_reg <= (2*SIGMA_W+CNT_W+VAR_W)'(ttn_reg)
                     * (2*SIGMA_W+CNT_W+VAR_W)'(var_reg);
        end
        if (load_out)
        begin
            out_value_reg <= (lhs_reg > rhs_reg) ? unsigned'(med) : {x_reg, 1'b0};
            out_last_reg  <= job_last_reg && (d_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            epos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        fill_reg <= fill_next;
                        if (q_cmd.last || q_cmd.emit)
                        begin
                            state_reg <= S_ACC;
                        end
                        else
                        begin
                            epos_reg <= epos_reg + CNT_W'(1);
                        end
                    end
                end
                S_ACC:
                begin
                    if (j_reg == hi_reg)
                    begin
                        state_reg <= S_M1;
                    end
                end
                S_M1:
                begin
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    if (load_out)
                    begin
                        if (!job_done)
                        begin
                            state_reg <= S_ACC;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                            if (job_last_reg)
                            begin
                                fill_reg <= '0;
                                epos_reg <= '0;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### design/window_outlier_median_replace_unit.sv
// Top level of the window outlier median replace unit.
// Usage:
//   s_axis carries one sample per request (tdata) with tlast on a column's last sample.
//   m_axis returns the results (tdata, Q16.1) with tlast on the column's last result.
//   cfg_we/cfg_data write the sigma multiplier (reset value 2).
//   Each sample's result appears once HALF_WINDOW later samples have arrived; the last
//   sample of a column flushes all pending results, oldest first.
// Sequence:
//   A sample that releases no result is taken in the idle state, and the engine stays idle.
//   A result passes these steps, n being its window size (up to 21 samples): the request
//   is taken, a pass over the n window entries forms the sum, square sum and rank count, then
//   three multiply steps and the output load follow. Each further result of a flush starts
//   again at the pass over its window. A two-entry request queue lets intake run ahead.
// Reset:
//   Clears the queue, the fill and pending counts and the output valid flag; the window
//   contents are don't-care until written.
// Stall:
//   A stalled receiver holds the output register; the engine waits on the next result,
//   then the queue fills and s_axis_tready drops.
`default_nettype none
module window_outlier_median_replace_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [womr_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [15:0] sample
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [womr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,   // [16:0] value, rest 0
    output logic                                   m_axis_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [womr_pkg::SIGMA_W-1:0]      cfg_data
);
    import womr_pkg::*;

    logic [SIGMA_W-1:0] sigma_reg;
    logic               push;
    logic               pop;
    cmd_t               cmd_in;
    cmd_t               cmd_out;
    q_stat_t            q_stat;
    logic [VALUE_W-1:0] value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_RESET;
        end
        else if (cfg_we)
        begin
            sigma_reg <= cfg_data;
        end
    end

    womr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_sample (s_axis_tdata[SAMPLE_W-1:0]),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .q_stat    (q_stat),
        .push      (push),
        .cmd       (cmd_in)
    );

    womr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd_in),
        .pop     (pop),
        .cmd_out (cmd_out),
        .stat    (q_stat)
    );

    womr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sigma     (sigma_reg),
        .q_stat    (q_stat),
        .q_cmd     (cmd_out),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_value (value),
        .out_last  (m_axis_tlast),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-VALUE_W){1'b0}}, value};

`ifndef NO_ASSERTIONS
    a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("request taken from an empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("request written into a full queue");
`endif
endmodule
`default_nettype wire
